/* hdl/scpu_pkg.sv */
package scpu_pkg;

    localparam int unsigned PC_W      = 12;
    localparam int unsigned XLEN      = 32;
    localparam int unsigned REG_N     = 16;
    localparam int unsigned IO_N      = 23;
    localparam int unsigned IO_IDX_W  = 5;
    localparam int unsigned IMM_W     = 12;

    localparam logic [7:0] OP_ADD  = 8'd0;
    localparam logic [7:0] OP_SUB  = 8'd1;
    localparam logic [7:0] OP_MAC  = 8'd2;
    localparam logic [7:0] OP_AND  = 8'd3;
    localparam logic [7:0] OP_OR   = 8'd4;
    localparam logic [7:0] OP_XOR  = 8'd5;
    localparam logic [7:0] OP_SLL  = 8'd6;
    localparam logic [7:0] OP_SRA  = 8'd7;
    localparam logic [7:0] OP_SRL  = 8'd8;
    localparam logic [7:0] OP_BEQ  = 8'd9;
    localparam logic [7:0] OP_BNE  = 8'd10;
    localparam logic [7:0] OP_BLT  = 8'd11;
    localparam logic [7:0] OP_BGT  = 8'd12;
    localparam logic [7:0] OP_BLE  = 8'd13;
    localparam logic [7:0] OP_BGE  = 8'd14;
    localparam logic [7:0] OP_JAL  = 8'd15;
    localparam logic [7:0] OP_LW   = 8'd16;
    localparam logic [7:0] OP_SW   = 8'd17;
    localparam logic [7:0] OP_RETI = 8'd18;
    localparam logic [7:0] OP_IN   = 8'd19;
    localparam logic [7:0] OP_OUT  = 8'd20;
    localparam logic [7:0] OP_HALT = 8'd21;

    localparam int unsigned IO_EN0     = 0;
    localparam int unsigned IO_EN1     = 1;
    localparam int unsigned IO_EN2     = 2;
    localparam int unsigned IO_ST0     = 3;
    localparam int unsigned IO_ST1     = 4;
    localparam int unsigned IO_ST2     = 5;
    localparam int unsigned IO_HANDLER = 6;
    localparam int unsigned IO_RETURN  = 7;
    localparam int unsigned IO_CLKS    = 8;
    localparam int unsigned IO_TMR_EN  = 11;
    localparam int unsigned IO_TMR_CUR = 12;
    localparam int unsigned IO_TMR_MAX = 13;
    localparam int unsigned IO_MON_CMD = 22;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic [PC_W-1:0]     next_pc;
        logic                halted;
        logic                reg_write;
        logic [3:0]          dest_register;
        logic [XLEN-1:0]     dest_value;
        logic                mem_write;
        logic [PC_W-1:0]     mem_address;
        logic [XLEN-1:0]     mem_value;
        logic                io_write;
        logic [IO_IDX_W-1:0] io_index;
        logic [XLEN-1:0]     io_value;
    } result_t;

endpackage

/* hdl/simple_cpu_execute_with_timer_irq_core.sv */
// Execute core for a small 32-bit machine with 48-bit instructions and timer IRQ.
// Input channel s_axis: one item is either an instruction to run (tuser = 0) or
// a data memory word to load (tuser = 1). tdata carries, lowest bit first:
// instruction_word, load_address, load_word, external_irq_event.
// Output channel m_axis: one result item per input item, tdata lowest bit first:
// next_pc, halted, reg_write, dest_register, dest_value, mem_write, mem_address,
// mem_value, io_write, io_index, io_value.
// The accept cycle reads the register file and issues the data memory read; in
// the execute state the core sees the registered memory data and commits all
// state and the result. The core accepts no new item until that commit.
// After reset the core clears every data memory word, one word per cycle,
// and holds s_axis_tready low meanwhile.
// A result waits in the output register while m_axis_tready is low; the next
// item is still accepted and its commit stalls until the output register frees.
module simple_cpu_execute_with_timer_irq_core #(
    parameter int unsigned DMEM_DEPTH = 4096
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // instruction_word, load_address, load_word, external_irq_event
    input  logic [95:0]  s_axis_tdata,
    // mode
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // next_pc, halted, reg_write, dest_register, dest_value, mem_write,
    // mem_address, mem_value, io_write, io_index, io_value
    output logic [135:0] m_axis_tdata
);
    import scpu_pkg::*;

    localparam int unsigned AW = (DMEM_DEPTH > 1) ? $clog2(DMEM_DEPTH) : 1;
    localparam int unsigned CW = AW + 1;

    logic [XLEN-1:0] dmem [DMEM_DEPTH];
    logic [XLEN-1:0] dmem_rdata_reg;

    logic [XLEN-1:0] regfile_reg [REG_N];
    logic [XLEN-1:0] io_reg [IO_N];
    logic [XLEN-1:0] io_next [IO_N];
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            ins_reg, ins_next;
    logic            halt_reg, halt_next;

    state_t state_reg, state_next;
    logic [CW-1:0] clr_cnt_reg;

    logic            mode_reg, ext_reg;
    logic [47:0]     instr_reg;
    logic [PC_W-1:0] load_addr_reg;
    logic [XLEN-1:0] load_word_reg;
    logic [XLEN-1:0] a_reg, b_reg, c_reg, d_reg, sum_reg;
    logic            addr_ok_reg;

    logic    out_valid_reg;
    result_t out_reg, res;

    logic accept, commit;

    logic [47:0]     s_instr;
    logic [XLEN-1:0] s_val [REG_N];
    logic [XLEN-1:0] s_sum;
    logic [PC_W-1:0] s_addr;

    logic [7:0]      op;
    logic [3:0]      rd;
    logic [PC_W-1:0] npc;
    logic            wr, take, mw, iow;
    logic [XLEN-1:0] val, mem_rd, ival;
    logic [63:0]     prod;
    logic [PC_W-1:0] maddr;
    logic            ld_ok;
    logic            io_ok;
    logic            irq;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign commit = (state_reg == ST_EXEC) && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = (state_reg == ST_IDLE);

    assign s_instr = s_axis_tdata[47:0];
    assign s_addr  = s_sum[PC_W-1:0];
    assign s_sum   = s_val[s_instr[35:32]] + s_val[s_instr[31:28]];

    always_comb
    begin
        for (int i = 0; i < REG_N; i++)
        begin
            s_val[i] = regfile_reg[i];
        end
        s_val[0] = '0;
        s_val[1] = {{(XLEN-IMM_W){s_instr[23]}}, s_instr[23:12]};
        s_val[2] = {{(XLEN-IMM_W){s_instr[11]}}, s_instr[11:0]};
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_cnt_reg == CW'(DMEM_DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (accept) state_next = ST_EXEC;
            ST_EXEC:  if (commit) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg      <= s_axis_tuser;
            instr_reg     <= s_instr;
            load_addr_reg <= s_axis_tdata[59:48];
            load_word_reg <= s_axis_tdata[91:60];
            ext_reg       <= s_axis_tdata[92];
            a_reg         <= s_val[s_instr[35:32]];
            b_reg         <= s_val[s_instr[31:28]];
            c_reg         <= s_val[s_instr[27:24]];
            d_reg         <= s_val[s_instr[39:36]];
            sum_reg       <= s_sum;
            addr_ok_reg   <= ({1'b0, s_addr} < 13'(DMEM_DEPTH));
        end
    end

    assign ld_ok = ({1'b0, load_addr_reg} < 13'(DMEM_DEPTH));

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            dmem[clr_cnt_reg[AW-1:0]] <= '0;
        end
        else if (commit && mode_reg && ld_ok)
        begin
            dmem[load_addr_reg[AW-1:0]] <= load_word_reg;
        end
        else if (commit && !mode_reg && !halt_reg && mw)
        begin
            dmem[maddr[AW-1:0]] <= d_reg + c_reg;
        end
        if (accept)
        begin
            dmem_rdata_reg <= dmem[s_addr[AW-1:0]];
        end
    end

    assign op    = instr_reg[47:40];
    assign rd    = instr_reg[39:36];
    assign prod  = a_reg * b_reg;
    assign io_ok = (sum_reg < XLEN'(IO_N));

    always_comb
    begin
        npc    = pc_reg + PC_W'(1);
        wr     = 1'b0;
        take   = 1'b0;
        mw     = 1'b0;
        iow    = 1'b0;
        val    = '0;
        maddr  = '0;
        ival   = '0;
        mem_rd = addr_ok_reg ? dmem_rdata_reg : '0;
        ins_next  = ins_reg;
        halt_next = halt_reg;
        for (int i = 0; i < IO_N; i++)
        begin
            io_next[i] = io_reg[i];
        end
        res = '0;

        case (op)
            OP_ADD:  begin val = a_reg + b_reg + c_reg; wr = 1'b1; end
            OP_SUB:  begin val = a_reg - b_reg - c_reg; wr = 1'b1; end
            OP_MAC:  begin val = prod[XLEN-1:0] + c_reg; wr = 1'b1; end
            OP_AND:  begin val = a_reg & b_reg & c_reg; wr = 1'b1; end
            OP_OR:   begin val = a_reg | b_reg | c_reg; wr = 1'b1; end
            OP_XOR:  begin val = a_reg ^ b_reg ^ c_reg; wr = 1'b1; end
            OP_SLL:  begin val = a_reg << b_reg[4:0]; wr = 1'b1; end
            OP_SRA:  begin val = XLEN'($signed(a_reg) >>> b_reg[4:0]); wr = 1'b1; end
            OP_SRL:  begin val = a_reg >> b_reg[4:0]; wr = 1'b1; end
            OP_BEQ:  take = (a_reg == b_reg);
            OP_BNE:  take = (a_reg != b_reg);
            OP_BLT:  take = ($signed(a_reg) < $signed(b_reg));
            OP_BGT:  take = ($signed(a_reg) > $signed(b_reg));
            OP_BLE:  take = ($signed(a_reg) <= $signed(b_reg));
            OP_BGE:  take = ($signed(a_reg) >= $signed(b_reg));
            OP_JAL:  begin val = XLEN'(npc); wr = 1'b1; take = 1'b1; end
            OP_LW:   begin val = mem_rd + c_reg; wr = 1'b1; end
            OP_SW:
            begin
                maddr = sum_reg[PC_W-1:0];
                mw    = addr_ok_reg;
            end
            OP_RETI:
            begin
                npc      = io_reg[IO_RETURN][PC_W-1:0];
                ins_next = 1'b0;
            end
            OP_IN:
            begin
                ival = io_ok ? io_reg[sum_reg[IO_IDX_W-1:0]] : '0;
                val  = ival;
                wr   = 1'b1;
            end
            OP_OUT:
            begin
                ival = c_reg;
                if (io_ok)
                begin
                    io_next[sum_reg[IO_IDX_W-1:0]] = c_reg;
                    iow = 1'b1;
                end
                if (io_next[IO_MON_CMD] == XLEN'(1))
                begin
                    io_next[IO_MON_CMD] = '0;
                end
            end
            OP_HALT:
            begin
                halt_next = 1'b1;
                npc       = pc_reg;
            end
            default: ;
        endcase
        if (take)
        begin
            npc = c_reg[PC_W-1:0];
        end
        if (rd <= 4'd2)
        begin
            wr = 1'b0;
        end

        if (io_next[IO_TMR_EN] != '0)
        begin
            if (io_next[IO_TMR_CUR] == io_next[IO_TMR_MAX])
            begin
                io_next[IO_TMR_CUR] = '0;
                io_next[IO_ST0]     = XLEN'(1);
            end
            else
            begin
                io_next[IO_TMR_CUR] = io_next[IO_TMR_CUR] + XLEN'(1);
            end
        end
        if (ext_reg)
        begin
            io_next[IO_ST2] = XLEN'(1);
        end
        irq = (((io_next[IO_EN0] & io_next[IO_ST0]) != '0) ||
               ((io_next[IO_EN1] & io_next[IO_ST1]) != '0) ||
               ((io_next[IO_EN2] & io_next[IO_ST2]) != '0)) && !ins_next;
        pc_next = npc;
        if (irq)
        begin
            ins_next           = 1'b1;
            io_next[IO_RETURN] = XLEN'(npc);
            pc_next            = io_next[IO_HANDLER][PC_W-1:0];
        end
        io_next[IO_CLKS] = io_next[IO_CLKS] + XLEN'(1);

        res.next_pc       = pc_next;
        res.halted        = halt_next;
        res.reg_write     = wr;
        res.dest_register = wr ? rd : '0;
        res.dest_value    = wr ? val : '0;
        res.mem_write     = mw;
        res.mem_address   = maddr;
        res.mem_value     = (op == OP_SW) ? d_reg + c_reg : '0;
        res.io_write      = iow;
        res.io_index      = (op == OP_IN || op == OP_OUT) ? sum_reg[IO_IDX_W-1:0] : '0;
        res.io_value      = ival;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= '0;
            ins_reg  <= 1'b0;
            halt_reg <= 1'b0;
            for (int i = 0; i < REG_N; i++)
            begin
                regfile_reg[i] <= '0;
            end
            for (int i = 0; i < IO_N; i++)
            begin
                io_reg[i] <= '0;
            end
        end
        else if (commit && !mode_reg && !halt_reg)
        begin
            pc_reg   <= pc_next;
            ins_reg  <= ins_next;
            halt_reg <= halt_next;
            if (wr)
            begin
                regfile_reg[rd] <= val;
            end
            for (int i = 0; i < IO_N; i++)
            begin
                io_reg[i] <= io_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            if (mode_reg || halt_reg)
            begin
                out_reg         <= '0;
                out_reg.next_pc <= pc_reg;
                out_reg.halted  <= halt_reg;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_reg.io_value, out_reg.io_index, out_reg.io_write,
                            out_reg.mem_value, out_reg.mem_address, out_reg.mem_write,
                            out_reg.dest_value, out_reg.dest_register, out_reg.reg_write,
                            out_reg.halted, out_reg.next_pc};

endmodule

/* tb/sv/simple_cpu_execute_with_timer_irq_core_chk.sv */
`timescale 1ns / 100ps

module simple_cpu_execute_with_timer_irq_core_chk (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,
    input  logic         s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [135:0] m_axis_tdata,
    output int           fail_count,
    output int           pending
);
    import scpu_pkg::*;

    localparam int DMEM_N = 4096;

    logic [XLEN-1:0] regs [REG_N];
    logic [XLEN-1:0] dmem [DMEM_N];
    logic [XLEN-1:0] io_regs [IO_N];
    logic [PC_W-1:0] pc;
    logic            in_service;
    logic            halt_flag;
    result_t         expected_q [$];

    function automatic logic [XLEN-1:0] sext12(logic [11:0] v);
        return {{20{v[11]}}, v};
    endfunction

    function automatic result_t execute_item(logic mode, logic [47:0] w, logic [11:0] la,
                                             logic [31:0] ldw, logic irq);
        result_t         r;
        logic [7:0]      op;
        logic [3:0]      rd, rs, rt, rm;
        logic [XLEN-1:0] a, b, c, d, sum, val;
        logic [PC_W-1:0] npc;
        logic            wr, take;
        r = '0;
        if (mode)
        begin
            dmem[la] = ldw;
            r.next_pc = pc;
            r.halted = halt_flag;
            return r;
        end
        if (halt_flag)
        begin
            r.next_pc = pc;
            r.halted = 1'b1;
            return r;
        end
        op = w[47:40];
        rd = w[39:36];
        rs = w[35:32];
        rt = w[31:28];
        rm = w[27:24];
        regs[0] = '0;
        regs[1] = sext12(w[23:12]);
        regs[2] = sext12(w[11:0]);
        a = regs[rs];
        b = regs[rt];
        c = regs[rm];
        d = regs[rd];
        sum = a + b;
        npc = pc + 1'b1;
        wr = 1'b0;
        take = 1'b0;
        val = '0;
        case (op)
            OP_ADD:  begin val = a + b + c; wr = 1'b1; end
            OP_SUB:  begin val = a - b - c; wr = 1'b1; end
            OP_MAC:  begin val = a * b + c; wr = 1'b1; end
            OP_AND:  begin val = a & b & c; wr = 1'b1; end
            OP_OR:   begin val = a | b | c; wr = 1'b1; end
            OP_XOR:  begin val = a ^ b ^ c; wr = 1'b1; end
            OP_SLL:  begin val = a << b[4:0]; wr = 1'b1; end
            OP_SRA:  begin val = $signed(a) >>> b[4:0]; wr = 1'b1; end
            OP_SRL:  begin val = a >> b[4:0]; wr = 1'b1; end
            OP_BEQ:  take = (a == b);
            OP_BNE:  take = (a != b);
            OP_BLT:  take = ($signed(a) < $signed(b));
            OP_BGT:  take = ($signed(a) > $signed(b));
            OP_BLE:  take = ($signed(a) <= $signed(b));
            OP_BGE:  take = ($signed(a) >= $signed(b));
            OP_JAL:  begin val = {20'd0, npc}; wr = 1'b1; take = 1'b1; end
            OP_LW:   begin val = dmem[sum[11:0]] + c; wr = 1'b1; end
            OP_SW:
            begin
                r.mem_address = sum[11:0];
                r.mem_value = d + c;
                r.mem_write = 1'b1;
                dmem[sum[11:0]] = d + c;
            end
            OP_RETI:
            begin
                npc = io_regs[IO_RETURN][11:0];
                in_service = 1'b0;
            end
            OP_IN:
            begin
                r.io_index = sum[4:0];
                r.io_value = (sum < IO_N) ? io_regs[sum] : '0;
                val = r.io_value;
                wr = 1'b1;
            end
            OP_OUT:
            begin
                r.io_index = sum[4:0];
                r.io_value = c;
                if (sum < IO_N)
                begin
                    io_regs[sum] = c;
                    r.io_write = 1'b1;
                end
                if (io_regs[IO_MON_CMD] == 1)
                    io_regs[IO_MON_CMD] = '0;
            end
            OP_HALT:
            begin
                halt_flag = 1'b1;
                npc = pc;
            end
            default: ;
        endcase
        if (take)
            npc = c[11:0];
        if (wr && rd > 2)
        begin
            regs[rd] = val;
            r.reg_write = 1'b1;
            r.dest_register = rd;
            r.dest_value = val;
        end
        pc = npc;
        if (io_regs[IO_TMR_EN] != 0)
        begin
            if (io_regs[IO_TMR_CUR] == io_regs[IO_TMR_MAX])
            begin
                io_regs[IO_TMR_CUR] = '0;
                io_regs[IO_ST0] = 1;
            end
            else
                io_regs[IO_TMR_CUR] = io_regs[IO_TMR_CUR] + 1;
        end
        if (irq)
            io_regs[IO_ST2] = 1;
        if (((io_regs[IO_EN0] & io_regs[IO_ST0]) != 0 ||
             (io_regs[IO_EN1] & io_regs[IO_ST1]) != 0 ||
             (io_regs[IO_EN2] & io_regs[IO_ST2]) != 0) && !in_service)
        begin
            in_service = 1'b1;
            io_regs[IO_RETURN] = {20'd0, pc};
            pc = io_regs[IO_HANDLER][11:0];
        end
        io_regs[IO_CLKS] = io_regs[IO_CLKS] + 1;
        r.next_pc = pc;
        r.halted = halt_flag;
        return r;
    endfunction

    function automatic result_t unpack_result(logic [135:0] t);
        result_t r;
        r.next_pc       = t[11:0];
        r.halted        = t[12];
        r.reg_write     = t[13];
        r.dest_register = t[17:14];
        r.dest_value    = t[49:18];
        r.mem_write     = t[50];
        r.mem_address   = t[62:51];
        r.mem_value     = t[94:63];
        r.io_write      = t[95];
        r.io_index      = t[100:96];
        r.io_value      = t[132:101];
        return r;
    endfunction

    initial
    begin
        foreach (regs[i]) regs[i] = '0;
        foreach (dmem[i]) dmem[i] = '0;
        foreach (io_regs[i]) io_regs[i] = '0;
        pc = '0;
        in_service = 1'b0;
        halt_flag = 1'b0;
        fail_count = 0;
    end

    assign pending = expected_q.size();

    always @(posedge clk)
    begin
        result_t got, exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = unpack_result(m_axis_tdata);
            if (expected_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result item %h", got);
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (got !== exp_r)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: expected %p actual %p", exp_r, got);
                end
            end
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
            expected_q.push_back(execute_item(s_axis_tuser, s_axis_tdata[47:0],
                                              s_axis_tdata[59:48], s_axis_tdata[91:60],
                                              s_axis_tdata[92]));
    end

endmodule

/* tb/sv/simple_cpu_execute_with_timer_irq_core_tb.sv */
`timescale 1ns / 100ps

module simple_cpu_execute_with_timer_irq_core_tb;
    import scpu_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;
    int           fail_count;
    int           pending;
    int           tx_idle_pct;
    int           rx_idle_pct;
    int           quiet_cycles = 0;

    always #2 clk = ~clk;

    simple_cpu_execute_with_timer_irq_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    simple_cpu_execute_with_timer_irq_core_chk i_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always @(posedge clk)
        if (rst_n)
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL simple_cpu_execute_with_timer_irq_core");
            $finish;
        end
    end

    task automatic send_item(logic mode, logic [47:0] w, logic [11:0] la, logic [31:0] ldw,
                             logic irq);
        bit done;
        done = 0;
        while (!done)
        begin
            if ($urandom_range(99) < tx_idle_pct)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= mode;
                s_axis_tdata  <= {3'b0, irq, ldw, la, w};
                @(negedge clk);
                while (!s_axis_tready)
                    @(negedge clk);
                @(posedge clk);
                done = 1;
            end
        end
    endtask

    task automatic run_insn(logic [7:0] op, logic [3:0] rd, logic [3:0] rs, logic [3:0] rt,
                            logic [3:0] rm, logic [11:0] imm1, logic [11:0] imm2);
        send_item(1'b0, {op, rd, rs, rt, rm, imm1, imm2}, 12'($urandom), $urandom, 1'b0);
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic random_items(int n);
        logic [47:0] w;
        for (int i = 0; i < n; i++)
        begin
            w = {$urandom, 16'($urandom)};
            if ($urandom_range(99) < 15)
            begin
                send_item(1'b1, w, 12'($urandom), $urandom, $urandom_range(99) < 5);
                continue;
            end
            case ($urandom_range(9))
                0:       w[47:40] = 8'($urandom_range(22, 255));
                1, 2:
                begin
                    w[47:40] = OP_OUT;
                    w[35:32] = 4'd0;
                    w[31:28] = 4'd1;
                    w[23:12] = 12'($urandom_range(0, 24));
                end
                3:       w[47:40] = OP_RETI;
                default:
                begin
                    w[47:40] = 8'($urandom_range(0, 20));
                    if (w[47:40] == OP_HALT)
                        w[47:40] = OP_ADD;
                end
            endcase
            send_item(1'b0, w, 12'($urandom), $urandom, $urandom_range(99) < 5);
        end
    endtask

    initial
    begin
        tx_idle_pct = 37;
        rx_idle_pct = 81;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(1'b1, '0, 12'd0, 32'hFFFF_FFFF, 1'b0);
        send_item(1'b1, '0, 12'hFFF, 32'h8000_0000, 1'b0);
        run_insn(OP_LW, 4'd3, 4'd0, 4'd0, 4'd0, 12'd0, 12'd0);
        run_insn(OP_LW, 4'd4, 4'd1, 4'd0, 4'd2, 12'hFFF, 12'h7FF);
        for (int op = OP_ADD; op <= OP_SRL; op++)
            run_insn(8'(op), 4'($urandom_range(3, 15)), 4'd1, 4'd2, 4'd3, 12'h800, 12'h7FF);
        run_insn(OP_SRA, 4'd5, 4'd1, 4'd2, 4'd0, 12'h800, 12'd31);
        for (int op = OP_BEQ; op <= OP_BGE; op++)
            run_insn(8'(op), 4'd0, 4'd1, 4'd2, 4'd1, 12'h800, 12'h7FF);
        run_insn(OP_JAL, 4'd6, 4'd0, 4'd0, 4'd6, 12'd0, 12'd0);
        run_insn(OP_SW, 4'd15, 4'd1, 4'd0, 4'd2, 12'hFFF, 12'h123);
        run_insn(OP_OUT, 4'd0, 4'd1, 4'd0, 4'd2, 12'd22, 12'd1);
        run_insn(OP_OUT, 4'd0, 4'd1, 4'd0, 4'd2, 12'd0, 12'd1);
        run_insn(OP_OUT, 4'd0, 4'd1, 4'd0, 4'd2, 12'd6, 12'h100);
        run_insn(OP_OUT, 4'd0, 4'd1, 4'd0, 4'd2, 12'd11, 12'd1);
        run_insn(OP_OUT, 4'd0, 4'd1, 4'd0, 4'd2, 12'd31, 12'd5);
        run_insn(OP_IN, 4'd7, 4'd1, 4'd0, 4'd0, 12'd8, 12'd0);
        run_insn(OP_IN, 4'd8, 4'd1, 4'd0, 4'd0, 12'd25, 12'd0);
        run_insn(OP_RETI, 4'd0, 4'd0, 4'd0, 4'd0, 12'd0, 12'd0);
        run_insn(8'd255, 4'd9, 4'd1, 4'd2, 4'd3, 12'd1, 12'd2);

        random_items(260);
        hold_until_drained();
        tx_idle_pct = 81;
        rx_idle_pct = 37;
        random_items(260);
        hold_until_drained();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_items(280);

        run_insn(OP_HALT, 4'd0, 4'd0, 4'd0, 4'd0, 12'd0, 12'd0);
        run_insn(OP_ADD, 4'd3, 4'd1, 4'd2, 4'd0, 12'd5, 12'd6);
        send_item(1'b1, '0, 12'd7, 32'h1234_5678, 1'b1);
        s_axis_tvalid <= 1'b0;

        for (int i = 0; i < STALL_LIMIT && pending != 0; i++)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS simple_cpu_execute_with_timer_irq_core");
        else
            $display("FAIL simple_cpu_execute_with_timer_irq_core");
        $finish;
    end

endmodule
